/* rtl/kwm_pkg.sv */
// Package with the shared types and codes of the k-way merge min-heap.
`default_nettype none

package kwm_pkg;

	localparam int TAG_BITS = 4;
	localparam int IN_VALUE_BITS = 32;
	localparam int OUT_COUNT_BITS = 5;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_ADVANCE = 2'd1;
	localparam logic [1:0] KIND_EXHAUST = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_EMPTY
	} kwm_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_CMP,
		ST_DN_CMP,
		ST_LAST,
		ST_WB,
		ST_FIN
	} kwm_state_t;

	typedef struct packed {
		logic [IN_VALUE_BITS-1:0] min_value;
		logic [TAG_BITS-1:0] min_tag;
		logic [OUT_COUNT_BITS-1:0] entry_count;
		logic is_empty;
		kwm_status_t status;
	} kwm_result_t;

endpackage

`default_nettype wire

/* rtl/kwm_mem.sv */
// Heap entry memory with one write port and two registered read ports.
`default_nettype none

module kwm_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 36
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic [$clog2(DEPTH)-1:0] rd_addr0,
	input wire logic [$clog2(DEPTH)-1:0] rd_addr1,
	output logic [WIDTH-1:0] rd_data0,
	output logic [WIDTH-1:0] rd_data1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data0 <= mem_q[rd_addr0];
		rd_data1 <= mem_q[rd_addr1];
	end

endmodule

`default_nettype wire

/* rtl/kwm_ctrl.sv */
// Heap sequencer: decodes requests and walks sift-up and sift-down through the memory.
`default_nettype none

module kwm_ctrl #(
	parameter int CAPACITY = 16,
	parameter int VALUE_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] kind,
	input wire logic signed [kwm_pkg::IN_VALUE_BITS-1:0] item_value,
	input wire logic [kwm_pkg::TAG_BITS-1:0] list_tag,
	output logic res_valid,
	input wire logic res_ready,
	output kwm_pkg::kwm_result_t res,
	output logic wr_en,
	output logic [$clog2(CAPACITY)-1:0] wr_addr,
	output logic [VALUE_BITS+kwm_pkg::TAG_BITS-1:0] wr_data,
	output logic [$clog2(CAPACITY)-1:0] rd_addr0,
	output logic [$clog2(CAPACITY)-1:0] rd_addr1,
	input wire logic [VALUE_BITS+kwm_pkg::TAG_BITS-1:0] rd_data0,
	input wire logic [VALUE_BITS+kwm_pkg::TAG_BITS-1:0] rd_data1
);

	import kwm_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;
	localparam int VW = VALUE_BITS;
	localparam int XW = (VW > IN_VALUE_BITS) ? VW : IN_VALUE_BITS;
	localparam int KW = (CW > OUT_COUNT_BITS) ? CW : OUT_COUNT_BITS;

	kwm_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] pos_q;
	logic [VW-1:0] hold_val_q;
	logic [TAG_BITS-1:0] hold_tag_q;
	logic [VW-1:0] root_val_q;
	logic [TAG_BITS-1:0] root_tag_q;
	kwm_status_t status_q;

	logic accept;
	logic is_full;
	logic is_zero;
	logic signed [XW-1:0] in_wide;
	logic [VW-1:0] in_val;
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] ins_pos;
	logic [AW-1:0] ins_parent;
	logic [AW-1:0] up_idx;
	logic [AW-1:0] up_parent;
	logic [IW-1:0] left_w;
	logic [IW-1:0] right_w;
	logic [IW-1:0] cnt_w;
	logic has_left;
	logic has_right;
	logic [VW-1:0] rd0_val;
	logic [VW-1:0] rd1_val;
	logic pick_right;
	logic [VW+TAG_BITS-1:0] pick_entry;
	logic [AW-1:0] pick_idx;
	logic [IW-1:0] pick_left_w;
	logic [IW-1:0] pick_right_w;
	logic up_swap;
	logic dn_swap;
	logic [XW-1:0] root_wide;
	logic [KW-1:0] cnt_wide;

	assign accept = in_valid && in_ready;
	assign is_full = (cnt_q == CW'(CAPACITY));
	assign is_zero = (cnt_q == '0);
	assign in_wide = XW'(item_value);
	assign in_val = in_wide[VW-1:0];
	assign cnt_m1 = cnt_q - CW'(1);
	assign ins_pos = cnt_q[AW-1:0];
	assign ins_parent = (ins_pos - AW'(1)) >> 1;
	assign up_idx = (pos_q - AW'(1)) >> 1;
	assign up_parent = (up_idx - AW'(1)) >> 1;

	// Children of the current node, held wide enough not to wrap.
	assign left_w = (IW'(pos_q) << 1) + IW'(1);
	assign right_w = left_w + IW'(1);
	assign cnt_w = IW'(cnt_q);
	assign has_left = (left_w < cnt_w);
	assign has_right = (right_w < cnt_w);

	assign rd0_val = rd_data0[VW-1:0];
	assign rd1_val = rd_data1[VW-1:0];

	// Right child wins only when strictly smaller than the left one.
	assign pick_right = has_right && ($signed(rd1_val) < $signed(rd0_val));
	assign pick_entry = pick_right ? rd_data1 : rd_data0;
	assign pick_idx = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
	assign pick_left_w = (IW'(pick_idx) << 1) + IW'(1);
	assign pick_right_w = pick_left_w + IW'(1);

	assign dn_swap = has_left && ($signed(pick_entry[VW-1:0]) < $signed(hold_val_q));
	assign up_swap = ($signed(hold_val_q) < $signed(rd0_val));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_INSERT: begin
							if (is_full) begin
								state_d = ST_FIN;
							end else if (is_zero) begin
								state_d = ST_WB;
							end else begin
								state_d = ST_UP_CMP;
							end
						end
						KIND_ADVANCE: state_d = is_zero ? ST_FIN : ST_DN_CMP;
						KIND_EXHAUST: state_d = is_zero ? ST_FIN : ST_LAST;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_UP_CMP: begin
				if (up_swap && (up_idx != '0)) begin
					state_d = ST_UP_CMP;
				end else begin
					state_d = ST_WB;
				end
			end
			ST_DN_CMP: state_d = dn_swap ? ST_DN_CMP : ST_WB;
			ST_LAST: state_d = ST_DN_CMP;
			ST_WB: state_d = ST_FIN;
			ST_FIN: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls and handshakes.
	always_comb begin
		in_ready = 1'b0;
		res_valid = 1'b0;
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_data = {hold_tag_q, hold_val_q};
		rd_addr0 = AW'(1);
		rd_addr1 = AW'(2);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (kind == KIND_INSERT) begin
					rd_addr0 = ins_parent;
				end else if (kind == KIND_EXHAUST) begin
					rd_addr0 = cnt_m1[AW-1:0];
				end
			end
			ST_UP_CMP: begin
				rd_addr0 = up_parent;
				if (up_swap) begin
					wr_en = 1'b1;
					wr_data = rd_data0;
				end
			end
			ST_DN_CMP: begin
				rd_addr0 = pick_left_w[AW-1:0];
				rd_addr1 = pick_right_w[AW-1:0];
				if (dn_swap) begin
					wr_en = 1'b1;
					wr_data = pick_entry;
				end
			end
			ST_LAST: begin
			end
			ST_WB: wr_en = 1'b1;
			ST_FIN: res_valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			status_q <= STAT_OK;
		end else begin
			state_q <= state_d;
			if (accept) begin
				status_q <= STAT_OK;
				unique case (kind)
					KIND_INSERT: begin
						if (is_full) begin
							status_q <= STAT_FULL;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					KIND_ADVANCE: begin
						if (is_zero) begin
							status_q <= STAT_EMPTY;
						end
					end
					KIND_EXHAUST: begin
						if (is_zero) begin
							status_q <= STAT_EMPTY;
						end else begin
							cnt_q <= cnt_m1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers: the entry being sifted and a mirror of the root.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (kind == KIND_INSERT) begin
				pos_q <= ins_pos;
				hold_val_q <= in_val;
				hold_tag_q <= list_tag;
			end else begin
				pos_q <= '0;
				hold_val_q <= in_val;
				hold_tag_q <= root_tag_q;
			end
		end else if (state_q == ST_UP_CMP && up_swap) begin
			pos_q <= up_idx;
		end else if (state_q == ST_DN_CMP && dn_swap) begin
			pos_q <= pick_idx;
		end else if (state_q == ST_LAST) begin
			hold_val_q <= rd0_val;
			hold_tag_q <= rd_data0[VW+TAG_BITS-1:VW];
		end
		if (wr_en && wr_addr == '0) begin
			root_val_q <= wr_data[VW-1:0];
			root_tag_q <= wr_data[VW+TAG_BITS-1:VW];
		end
	end

	assign root_wide = XW'(root_val_q);
	assign cnt_wide = KW'(cnt_q);

	always_comb begin
		res.min_value = is_zero ? '0 : root_wide[IN_VALUE_BITS-1:0];
		res.min_tag = is_zero ? '0 : root_tag_q;
		res.entry_count = cnt_wide[OUT_COUNT_BITS-1:0];
		res.is_empty = is_zero;
		res.status = status_q;
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("heap count exceeds capacity");

	a_no_stray_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_FIN || state_q == ST_LAST) |-> !wr_en)
		else $error("memory written outside a sift step");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_INSERT && !is_full) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the heap");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == STAT_FULL) |-> is_full)
		else $error("full status reported with room left");

	a_up_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UP_CMP |-> pos_q != '0)
		else $error("sift-up compare at the root");
`endif

endmodule

`default_nettype wire

/* rtl/k_way_merge_min_heap_top.sv */
// Top level of the k-way merge min-heap: stream ports, heap memory and result register.
`default_nettype none

// Binary min-heap of list heads for merging up to CAPACITY sorted lists. Each request
// carries a kind in s_tuser: insert places a new head (value and list tag) and sifts it
// up, advance replaces the root value with the next value of the root's list and sifts it
// down, and exhaust moves the last entry to the root and sifts it down. Ties never swap:
// an entry moves up only past a strictly greater parent, and moves down only below a
// strictly smaller child, the right child being chosen only when strictly smaller than
// the left. Every request yields exactly one result with the root value and tag (both
// zero when empty), the entry count and an empty flag, plus a status in m_tuser: ok,
// insert while full, or advance/exhaust while empty (both leave the heap unchanged);
// kind code 3 changes nothing and reports ok. Entries live in a single memory with one
// write port and two registered reads. One request is handled at a time: a rejected or
// no-op request goes straight to its result, an insert compares up the tree level by
// level and then writes the entry back, an advance does the same down the tree, and an
// exhaust first reads the last entry. The result register lets the heap finish a request
// while the previous result still waits on m_tready. No clearing pass follows reset.
module k_way_merge_min_heap_top #(
	parameter int CAPACITY = 16,
	parameter int VALUE_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [39:0] s_tdata,  // item_value[31:0], list_tag[35:32], zero[39:36]
	input wire logic [1:0] s_tuser,   // kind[1:0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [47:0] m_tdata,      // min_value[31:0], min_tag[35:32], entry_count[40:36],
	                                  // is_empty[41], zero[47:42]
	output logic [1:0] m_tuser        // status[1:0]
);

	import kwm_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int EW = VALUE_BITS + TAG_BITS;

	logic res_valid;
	logic res_ready;
	kwm_result_t res;
	kwm_result_t res_q;
	logic out_valid_q;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic [AW-1:0] rd_addr0;
	logic [AW-1:0] rd_addr1;
	logic [EW-1:0] rd_data0;
	logic [EW-1:0] rd_data1;

	kwm_ctrl #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.kind(s_tuser),
		.item_value(s_tdata[31:0]),
		.list_tag(s_tdata[35:32]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr0(rd_addr0),
		.rd_addr1(rd_addr1),
		.rd_data0(rd_data0),
		.rd_data1(rd_data1)
	);

	kwm_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(EW)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr0(rd_addr0),
		.rd_addr1(rd_addr1),
		.rd_data0(rd_data0),
		.rd_data1(rd_data1)
	);

	// The result register is free when empty or being drained this cycle.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, res_q.is_empty, res_q.entry_count, res_q.min_tag, res_q.min_value};
	assign m_tuser = res_q.status;

endmodule

`default_nettype wire
